// File: sv/mldc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mldc_pkg;

  // Ticks counted after reset before the control rules run
  localparam int STARTUP_SKIP_TICKS = 5;
  localparam int SKIP_W             = 3;
  localparam logic [SKIP_W-1:0] SKIP_DONE = SKIP_W'(STARTUP_SKIP_TICKS);

  // Request kinds
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_TRIP    = 2'd1;
  localparam logic [1:0] REQ_RESTORE = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_WAIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CHECK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_LIMIT = 3'd4;

  // Disconnect control modes
  localparam logic [2:0] MODE_0       = 3'd0;
  localparam logic [2:0] MODE_1       = 3'd1;
  localparam logic [2:0] MODE_2       = 3'd2;
  localparam logic [2:0] MODE_4       = 3'd4;
  localparam logic [2:0] MODE_5       = 3'd5;
  localparam logic [2:0] MODE_6       = 3'd6;
  localparam logic [2:0] MODE_INVALID = 3'd7;
  localparam logic [2:0] MODE_RESET   = MODE_6;

  // Control state, one-hot internally
  typedef enum logic [2:0] {
    CS_DISC  = 3'b001,
    CS_CONN  = 3'b010,
    CS_READY = 3'b100
  } cstate_t;

  // Reported control state codes
  localparam logic [1:0] STATE_CODE_DISC  = 2'd0;
  localparam logic [1:0] STATE_CODE_CONN  = 2'd1;
  localparam logic [1:0] STATE_CODE_READY = 2'd2;

  typedef struct packed {
    logic [2:0]  control_mode;
    logic [15:0] normal_wait_time;
    logic [15:0] lockout_wait_time;
    logic [15:0] load_check_time;
    logic [7:0]  reconnect_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       overload_event;
    logic       overcurrent_event;
    logic       overload_live;
    logic       overcurrent_live;
    logic       overload_registered;
    logic       overcurrent_registered;
    logic       remote_connect;
    logic       manual_connect;
  } item_t;

  typedef struct packed {
    cstate_t           ctrl_state;
    logic              latch_is_open;
    logic              local_wants_disconnect;
    logic [15:0]       wait_counter;
    logic [15:0]       check_counter;
    logic [7:0]        reconnect_tally;
    logic [SKIP_W-1:0] startup_skip;
  } state_t;

  typedef struct packed {
    logic       latch_open;
    logic [1:0] control_state;
    logic       latch_changed;
    logic       state_changed;
  } result_t;

  function automatic logic [1:0] state_code(cstate_t s);
    logic [1:0] code;
    unique case (s)
      CS_DISC:  code = STATE_CODE_DISC;
      CS_CONN:  code = STATE_CODE_CONN;
      CS_READY: code = STATE_CODE_READY;
      default:  code = STATE_CODE_DISC;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: sv/mldc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mldc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       overload_event;
  logic       overcurrent_event;
  logic       overload_live;
  logic       overcurrent_live;
  logic       overload_registered;
  logic       overcurrent_registered;
  logic       remote_connect;
  logic       manual_connect;

  modport source (
    output valid, req_type, overload_event, overcurrent_event, overload_live,
           overcurrent_live, overload_registered, overcurrent_registered,
           remote_connect, manual_connect,
    input  ready
  );

  modport sink (
    input  valid, req_type, overload_event, overcurrent_event, overload_live,
           overcurrent_live, overload_registered, overcurrent_registered,
           remote_connect, manual_connect,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/mldc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mldc_rsp_if;
  logic       valid;
  logic       ready;
  logic       latch_open;
  logic [1:0] control_state;
  logic       latch_changed;
  logic       state_changed;

  modport source (
    output valid, latch_open, control_state, latch_changed, state_changed,
    input  ready
  );

  modport sink (
    input  valid, latch_open, control_state, latch_changed, state_changed,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/mldc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mldc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mldc_pkg::CFG_DATA_W-1:0] cfg_data,
  output mldc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode      <= mldc_pkg::MODE_RESET;
      cfg.normal_wait_time  <= '0;
      cfg.lockout_wait_time <= '0;
      cfg.load_check_time   <= '0;
      cfg.reconnect_limit   <= '0;
    end else if (cfg_we) begin
      // drop writes to indexes past the register list
      unique case (cfg_index)
        mldc_pkg::CFG_CONTROL_MODE:    cfg.control_mode      <= cfg_data[2:0];
        mldc_pkg::CFG_NORMAL_WAIT:     cfg.normal_wait_time  <= cfg_data;
        mldc_pkg::CFG_LOCKOUT_WAIT:    cfg.lockout_wait_time <= cfg_data;
        mldc_pkg::CFG_LOAD_CHECK:      cfg.load_check_time   <= cfg_data;
        mldc_pkg::CFG_RECONNECT_LIMIT: cfg.reconnect_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/mldc_step_logic.sv
`timescale 1ns / 1ps
`default_nettype none

module mldc_step_logic (
  input  wire mldc_pkg::state_t  st,
  input  wire mldc_pkg::cfg_t    cfg,
  input  wire mldc_pkg::item_t   item,
  output mldc_pkg::state_t       st_next,
  output mldc_pkg::result_t      res
);

  logic fault;
  logic local_conn;
  logic man_rule;
  logic loc_rule;
  logic local_ok;

  assign fault = (item.overload_event && item.overload_live) ||
                 (item.overcurrent_event && item.overcurrent_live);

  always_comb begin
    st_next    = st;
    local_conn = 1'b1;
    man_rule   = 1'b0;
    loc_rule   = 1'b0;
    local_ok   = 1'b0;

    unique case (item.req_type)
      mldc_pkg::REQ_TICK: begin
        if (st.startup_skip < mldc_pkg::SKIP_DONE) begin
          st_next.startup_skip = st.startup_skip + 1'b1;
        end
        if (st_next.startup_skip >= mldc_pkg::SKIP_DONE) begin
          // load check: decrement on a live monitored fault, else reload
          if (st.check_counter != 16'd0) begin
            if (fault) begin
              st_next.check_counter = st.check_counter - 16'd1;
            end else begin
              st_next.check_counter = cfg.load_check_time;
            end
            if (st_next.check_counter == 16'd0) begin
              st_next.reconnect_tally = st.reconnect_tally + 8'd1;
              if (st_next.reconnect_tally < cfg.reconnect_limit) begin
                st_next.wait_counter = cfg.normal_wait_time;
              end else if (st_next.reconnect_tally == cfg.reconnect_limit) begin
                st_next.wait_counter = cfg.lockout_wait_time;
              end else begin
                st_next.reconnect_tally = 8'd0;
                st_next.wait_counter    = cfg.normal_wait_time;
              end
              st_next.local_wants_disconnect = 1'b1;
            end
          end
          // wait timer: on expiry start the load check and release the request
          if (st_next.wait_counter != 16'd0) begin
            st_next.wait_counter = st_next.wait_counter - 16'd1;
            if (st_next.wait_counter == 16'd0) begin
              st_next.check_counter          = cfg.load_check_time;
              st_next.local_wants_disconnect = 1'b0;
            end
          end

          local_conn = !st_next.local_wants_disconnect;
          if (cfg.control_mode == mldc_pkg::MODE_0) begin
            st_next.latch_is_open = 1'b0;
            st_next.ctrl_state    = mldc_pkg::CS_CONN;
          end else if (cfg.control_mode != mldc_pkg::MODE_INVALID) begin
            unique case (st.ctrl_state)
              mldc_pkg::CS_DISC: begin
                if (item.remote_connect) begin
                  if (cfg.control_mode == mldc_pkg::MODE_2 ||
                      cfg.control_mode == mldc_pkg::MODE_4) begin
                    st_next.latch_is_open = 1'b0;
                    st_next.ctrl_state    = mldc_pkg::CS_CONN;
                  end else begin
                    st_next.ctrl_state = mldc_pkg::CS_READY;
                  end
                end
              end
              mldc_pkg::CS_READY: begin
                local_ok = (cfg.control_mode == mldc_pkg::MODE_5 ||
                            cfg.control_mode == mldc_pkg::MODE_6) && local_conn;
                if (item.manual_connect || local_ok) begin
                  st_next.latch_is_open = 1'b0;
                  st_next.ctrl_state    = mldc_pkg::CS_CONN;
                end
                if (!item.remote_connect) begin
                  st_next.latch_is_open = 1'b1;
                  st_next.ctrl_state    = mldc_pkg::CS_DISC;
                end
              end
              mldc_pkg::CS_CONN: begin
                man_rule = (cfg.control_mode != mldc_pkg::MODE_6) && !item.manual_connect;
                loc_rule = (cfg.control_mode == mldc_pkg::MODE_1 ||
                            cfg.control_mode == mldc_pkg::MODE_2 ||
                            cfg.control_mode == mldc_pkg::MODE_5 ||
                            cfg.control_mode == mldc_pkg::MODE_6) && !local_conn;
                if (!item.remote_connect) begin
                  st_next.latch_is_open = 1'b1;
                  st_next.ctrl_state    = mldc_pkg::CS_DISC;
                end
                if (man_rule || loc_rule) begin
                  st_next.latch_is_open = 1'b1;
                  st_next.ctrl_state    = mldc_pkg::CS_READY;
                end
              end
              default: ;
            endcase
          end
        end
      end
      mldc_pkg::REQ_TRIP: begin
        // start a new sequence only when no timer runs
        if (st.check_counter == 16'd0 && st.wait_counter == 16'd0) begin
          st_next.wait_counter           = cfg.normal_wait_time;
          st_next.reconnect_tally        = 8'd0;
          st_next.local_wants_disconnect = 1'b1;
        end
      end
      mldc_pkg::REQ_RESTORE: begin
        if (!item.overload_registered && !item.overcurrent_registered) begin
          st_next.wait_counter           = 16'd0;
          st_next.check_counter          = 16'd0;
          st_next.reconnect_tally        = 8'd0;
          st_next.local_wants_disconnect = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // latch, state code, latch changed, state changed
  assign res = {st_next.latch_is_open,
                mldc_pkg::state_code(st_next.ctrl_state),
                st_next.latch_is_open != st.latch_is_open,
                st_next.ctrl_state != st.ctrl_state};

endmodule

`default_nettype wire

// File: sv/meter_load_disconnect_control_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Supply disconnect controller, DLMS disconnect control modes 0 to 6.
// cmd carries one beat per request: a one-second tick, a local trip or a
// local restore, with the monitoring flags and the remote and manual
// command levels. rsp returns exactly one beat per request: the latch,
// the control state and whether either changed on that request.
// The cfg_we / cfg_index / cfg_data port writes the mode, the wait and
// load-check times and the reconnect limit; write it only while idle.
// A request is captured in the input register, where the next-state logic
// runs against the control registers, and its result is then loaded into
// the result register and offered on rsp. Throughput: one request per
// cycle while rsp does not stall, set by the state update loop through
// the step logic.
// When rsp stalls the result register holds, the input register fills,
// and cmd.ready drops until the result beat is taken.
// Reset (rst, synchronous) puts the controller in connected with the
// latch closed, clears the timers, tally and startup count, restores the
// default configuration (mode 6, zero times and limit) and empties both
// registers. The first four ticks after reset report the state only.

module meter_load_disconnect_control_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mldc_cmd_if.sink                             cmd,
  mldc_rsp_if.source                           rsp,
  input  wire logic                            cfg_we,
  input  wire logic [mldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mldc_pkg::CFG_DATA_W-1:0] cfg_data
);

  mldc_pkg::cfg_t    cfg;
  mldc_pkg::state_t  st;
  mldc_pkg::state_t  st_next;
  mldc_pkg::item_t   item;
  mldc_pkg::result_t res;
  mldc_pkg::result_t res_q;

  logic item_valid;
  logic res_valid;
  logic advance;

  mldc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mldc_step_logic u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  // move the held request on whenever the result register is free
  assign advance   = !res_valid || rsp.ready;
  assign cmd.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item.req_type               <= cmd.req_type;
      item.overload_event         <= cmd.overload_event;
      item.overcurrent_event      <= cmd.overcurrent_event;
      item.overload_live          <= cmd.overload_live;
      item.overcurrent_live       <= cmd.overcurrent_live;
      item.overload_registered    <= cmd.overload_registered;
      item.overcurrent_registered <= cmd.overcurrent_registered;
      item.remote_connect         <= cmd.remote_connect;
      item.manual_connect         <= cmd.manual_connect;
    end
  end

  // controller state: advance once per request as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.ctrl_state             <= mldc_pkg::CS_CONN;
      st.latch_is_open          <= 1'b0;
      st.local_wants_disconnect <= 1'b0;
      st.wait_counter           <= '0;
      st.check_counter          <= '0;
      st.reconnect_tally        <= '0;
      st.startup_skip           <= '0;
    end else if (item_valid && advance) begin
      st <= st_next;
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res_q <= res;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.latch_open    = res_q.latch_open;
  assign rsp.control_state = res_q.control_state;
  assign rsp.latch_changed = res_q.latch_changed;
  assign rsp.state_changed = res_q.state_changed;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mldc_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
  localparam logic [2:0] MODE_3         = 3'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLD_CYCLES    = 60;
  localparam int         HOLD_AFTER     = 120;

  // Local copy of the disconnect controller: tracks control state, latch and
  // protection counters and queues the status beat each request produces.
  class disconnect_scoreboard;
    cfg_t        regs;
    logic [1:0]  cstate;
    logic        latch;
    logic        wants_disc;
    logic [15:0] wait_cnt;
    logic [15:0] check_cnt;
    logic [7:0]  tally;
    logic [2:0]  skip_cnt;
    result_t     pending[$];
    int          errors;
    int          checked;
    int          ticks;
    int          trips;
    int          restores;
    int          state_moves;
    int          max_tally;

    function new();
      regs.control_mode      = MODE_RESET;
      regs.normal_wait_time  = '0;
      regs.lockout_wait_time = '0;
      regs.load_check_time   = '0;
      regs.reconnect_limit   = '0;
      cstate      = STATE_CODE_CONN;
      latch       = 1'b0;
      wants_disc  = 1'b0;
      wait_cnt    = '0;
      check_cnt   = '0;
      tally       = '0;
      skip_cnt    = '0;
      errors      = 0;
      checked     = 0;
      ticks       = 0;
      trips       = 0;
      restores    = 0;
      state_moves = 0;
      max_tally   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CONTROL_MODE:    regs.control_mode      = data[2:0];
        CFG_NORMAL_WAIT:     regs.normal_wait_time  = data;
        CFG_LOCKOUT_WAIT:    regs.lockout_wait_time = data;
        CFG_LOAD_CHECK:      regs.load_check_time   = data;
        CFG_RECONNECT_LIMIT: regs.reconnect_limit   = data[7:0];
        default: ;
      endcase
    endfunction

    // Load check first, then the hold-off wait.
    function void protect_tick(item_t it);
      logic fault;
      if (check_cnt != 0) begin
        fault = (it.overload_event && it.overload_live) ||
                (it.overcurrent_event && it.overcurrent_live);
        check_cnt = fault ? check_cnt - 16'd1 : regs.load_check_time;
        if (check_cnt == 0) begin
          tally = tally + 8'd1;
          if (tally < regs.reconnect_limit) begin
            wait_cnt = regs.normal_wait_time;
          end else if (tally == regs.reconnect_limit) begin
            wait_cnt = regs.lockout_wait_time;
          end else begin
            tally    = '0;
            wait_cnt = regs.normal_wait_time;
          end
          wants_disc = 1'b1;
          if (tally > max_tally) max_tally = tally;
        end
      end
      if (wait_cnt != 0) begin
        wait_cnt = wait_cnt - 16'd1;
        if (wait_cnt == 0) begin
          check_cnt  = regs.load_check_time;
          wants_disc = 1'b0;
        end
      end
    endfunction

    // Rules are applied in order; a later rule overrides an earlier one.
    function void apply_mode(logic remote, logic manual);
      logic [2:0] m;
      logic       local_conn;
      logic       man_rule;
      logic       loc_rule;
      m          = regs.control_mode;
      local_conn = !wants_disc;
      if (m == MODE_0) begin
        latch  = 1'b0;
        cstate = STATE_CODE_CONN;
        return;
      end
      if (m == MODE_INVALID) return;
      case (cstate)
        STATE_CODE_DISC: begin
          if (remote) begin
            if (m == MODE_2 || m == MODE_4) begin
              latch  = 1'b0;
              cstate = STATE_CODE_CONN;
            end else begin
              cstate = STATE_CODE_READY;
            end
          end
        end
        STATE_CODE_READY: begin
          if (manual || ((m == MODE_5 || m == MODE_6) && local_conn)) begin
            latch  = 1'b0;
            cstate = STATE_CODE_CONN;
          end
          if (!remote) begin
            latch  = 1'b1;
            cstate = STATE_CODE_DISC;
          end
        end
        STATE_CODE_CONN: begin
          man_rule = (m != MODE_6) && !manual;
          loc_rule = (m == MODE_1 || m == MODE_2 || m == MODE_5 || m == MODE_6) &&
                     !local_conn;
          if (!remote) begin
            latch  = 1'b1;
            cstate = STATE_CODE_DISC;
          end
          if (man_rule || loc_rule) begin
            latch  = 1'b1;
            cstate = STATE_CODE_READY;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_input(item_t it);
      logic       old_latch;
      logic [1:0] old_state;
      result_t    exp_res;
      old_latch = latch;
      old_state = cstate;
      case (it.req_type)
        REQ_TICK: begin
          ticks++;
          if (skip_cnt < SKIP_DONE) skip_cnt = skip_cnt + 3'd1;
          if (skip_cnt >= SKIP_DONE) begin
            protect_tick(it);
            apply_mode(it.remote_connect, it.manual_connect);
          end
        end
        REQ_TRIP: begin
          if (check_cnt == 0 && wait_cnt == 0) begin
            trips++;
            wait_cnt   = regs.normal_wait_time;
            tally      = '0;
            wants_disc = 1'b1;
          end
        end
        REQ_RESTORE: begin
          if (!it.overload_registered && !it.overcurrent_registered) begin
            restores++;
            wait_cnt   = '0;
            check_cnt  = '0;
            tally      = '0;
            wants_disc = 1'b0;
          end
        end
        default: ;
      endcase
      exp_res.latch_open    = latch;
      exp_res.control_state = cstate;
      exp_res.latch_changed = (latch != old_latch);
      exp_res.state_changed = (cstate != old_state);
      if (exp_res.state_changed) state_moves++;
      pending.push_back(exp_res);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %b",
                 $time, act);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      compare_field("latch_open", exp_res.latch_open, act.latch_open);
      compare_field("control_state", exp_res.control_state, act.control_state);
      compare_field("latch_changed", exp_res.latch_changed, act.latch_changed);
      compare_field("state_changed", exp_res.state_changed, act.state_changed);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    gaps_on;
  bit                    hold_done;
  int                    idle_cycles;
  disconnect_scoreboard  sb;

  mldc_cmd_if cmd_ch ();
  mldc_rsp_if rsp_ch ();

  meter_load_disconnect_control_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Build one request; flags are, MSB first: overload_event, overcurrent_event,
  // overload_live, overcurrent_live, overload_registered, overcurrent_registered,
  // remote_connect, manual_connect.
  function automatic item_t make_item(logic [1:0] kind, logic [7:0] flags);
    return {kind, flags};
  endfunction

  // Mostly ticks so the protection sequence gets to run; restores are often
  // blocked by a registered event.
  function automatic item_t random_item();
    item_t it;
    int    roll;
    it   = 10'($urandom);
    roll = $urandom_range(99);
    if (roll < 64)      it.req_type = REQ_TICK;
    else if (roll < 78) it.req_type = REQ_TRIP;
    else if (roll < 92) it.req_type = REQ_RESTORE;
    else                it.req_type = REQ_UNKNOWN;
    if (it.req_type == REQ_RESTORE) begin
      it.overload_registered    = ($urandom_range(3) == 0);
      it.overcurrent_registered = ($urandom_range(3) == 0);
    end
    return it;
  endfunction

  // Offer one beat, idling at random first; hold valid until accepted.
  task automatic send_item(item_t it);
    while (gaps_on && $urandom_range(99) < 31) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid                  <= 1'b1;
    cmd_ch.req_type               <= it.req_type;
    cmd_ch.overload_event         <= it.overload_event;
    cmd_ch.overcurrent_event      <= it.overcurrent_event;
    cmd_ch.overload_live          <= it.overload_live;
    cmd_ch.overcurrent_live       <= it.overcurrent_live;
    cmd_ch.overload_registered    <= it.overload_registered;
    cmd_ch.overcurrent_registered <= it.overcurrent_registered;
    cmd_ch.remote_connect         <= it.remote_connect;
    cmd_ch.manual_connect         <= it.manual_connect;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Drain, reprogram every register, then run a batch of random requests.
  task automatic run_phase(logic [2:0] mode, logic [15:0] nwait, logic [15:0] lwait,
                           logic [15:0] lcheck, logic [7:0] limit, int count);
    wait_drained();
    write_reg(CFG_CONTROL_MODE, 16'(mode));
    write_reg(CFG_NORMAL_WAIT, nwait);
    write_reg(CFG_LOCKOUT_WAIT, lwait);
    write_reg(CFG_LOAD_CHECK, lcheck);
    write_reg(CFG_RECONNECT_LIMIT, 16'(limit));
    cfg_we <= 1'b0;
    repeat (count) send_item(random_item());
    cmd_ch.valid <= 1'b0;
  endtask

  // Receiver: random backpressure, plus one long hold-off while the sender
  // keeps offering, so the input register fills and cmd.ready drops.
  initial begin
    rsp_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= 31);
      end
    end
  end

  // Check every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result({rsp_ch.latch_open, rsp_ch.control_state, rsp_ch.latch_changed,
                       rsp_ch.state_changed});
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               sb.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sb = new();
    gaps_on = 1'b1;
    rst                           <= 1'b1;
    cfg_we                        <= 1'b0;
    cfg_index                     <= '0;
    cfg_data                      <= '0;
    cmd_ch.valid                  <= 1'b0;
    cmd_ch.req_type               <= REQ_TICK;
    cmd_ch.overload_event         <= 1'b0;
    cmd_ch.overcurrent_event      <= 1'b0;
    cmd_ch.overload_live          <= 1'b0;
    cmd_ch.overcurrent_live       <= 1'b0;
    cmd_ch.overload_registered    <= 1'b0;
    cmd_ch.overcurrent_registered <= 1'b0;
    cmd_ch.remote_connect         <= 1'b0;
    cmd_ch.manual_connect         <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on reset configuration: mode 6, zero times and limit.
    send_item(make_item(REQ_UNKNOWN, 8'b1111_1111));   // unknown kind: report only
    send_item(make_item(REQ_TRIP,    8'b0000_0000));   // trip with zero wait: latch request
    send_item(make_item(REQ_RESTORE, 8'b0000_1000));   // restore blocked by overload
    send_item(make_item(REQ_RESTORE, 8'b0000_0100));   // restore blocked by overcurrent
    send_item(make_item(REQ_TICK,    8'b0000_0000));   // startup ticks: no rule runs
    send_item(make_item(REQ_TICK,    8'b1111_1111));
    send_item(make_item(REQ_TICK,    8'b0000_1111));
    send_item(make_item(REQ_TICK,    8'b1111_0000));
    send_item(make_item(REQ_TICK,    8'b0000_0011));   // first live tick: local rule -> ready
    send_item(make_item(REQ_TICK,    8'b0000_0010));   // ready, local still wants off: hold
    send_item(make_item(REQ_RESTORE, 8'b0000_0000));   // restore clears the local request
    send_item(make_item(REQ_TICK,    8'b0000_0010));   // ready, local ok -> connected
    send_item(make_item(REQ_TICK,    8'b0000_0000));   // remote off -> disconnected
    send_item(make_item(REQ_TICK,    8'b0000_0000));   // stay disconnected
    send_item(make_item(REQ_TICK,    8'b0000_0010));   // remote on -> ready
    send_item(make_item(REQ_TICK,    8'b0000_0001));   // manual on but remote off: later wins
    send_item(make_item(REQ_TICK,    8'b0000_0010));
    send_item(make_item(REQ_TICK,    8'b0000_0011));   // manual connect -> connected
    send_item(make_item(REQ_TRIP,    8'b1111_1111));
    send_item(make_item(REQ_TICK,    8'b0000_0001));   // remote off and local rule: ready wins
    send_item(make_item(REQ_RESTORE, 8'b0000_0011));
    send_item(make_item(REQ_TICK,    8'b1111_0010));
    cmd_ch.valid <= 1'b0;

    // Tally wrap: one-tick wait and check, limit 255; every faulty tick after the first
    // steps the tally, through the lockout and back to zero. Run without idling.
    wait_drained();
    write_reg(CFG_CONTROL_MODE, 16'(MODE_5));
    write_reg(CFG_NORMAL_WAIT, 16'd1);
    write_reg(CFG_LOCKOUT_WAIT, 16'd1);
    write_reg(CFG_LOAD_CHECK, 16'd1);
    write_reg(CFG_RECONNECT_LIMIT, 16'd255);
    cfg_we <= 1'b0;
    gaps_on = 1'b0;
    send_item(make_item(REQ_RESTORE, 8'b0000_0000));
    send_item(make_item(REQ_TRIP, 8'(($urandom))));
    repeat (260) begin
      send_item(make_item(REQ_TICK, 8'($urandom) | 8'b1010_0000));
    end
    cmd_ch.valid <= 1'b0;
    gaps_on = 1'b1;

    // Random phases across all modes, extremes of the times and limit.
    run_phase(MODE_0,       16'd2,     16'd3,     16'd2,     8'd1,   18);
    run_phase(MODE_1,       16'd1,     16'd4,     16'd2,     8'd2,   18);
    run_phase(MODE_2,       16'd3,     16'd1,     16'd3,     8'd0,   18);
    run_phase(MODE_3,       16'd0,     16'd0,     16'd0,     8'd0,   18);
    run_phase(MODE_4,       16'd2,     16'd5,     16'd1,     8'd3,   18);
    run_phase(MODE_INVALID, 16'hFFFF,  16'hFFFF,  16'hFFFF,  8'hFF,  14);
    run_phase(MODE_5,       16'd2,     16'd0,     16'd3,     8'd2,   18);
    run_phase(MODE_6,       16'd1,     16'd2,     16'd2,     8'd1,   18);
    run_phase(3'($urandom_range(7)), 16'($urandom_range(4)), 16'($urandom_range(4)),
              16'($urandom_range(4)), 8'($urandom_range(3)), 18);

    // Drain, then let the pipeline settle before the summary.
    wait_drained();
    repeat (6) @(posedge clk);

    $display("Covered %0d ticks, %0d trips and %0d restores taking effect, %0d state changes,",
             sb.ticks, sb.trips, sb.restores, sb.state_moves);
    $display("modes 0 to 7, tally up to %0d with wrap; %0d result beats checked.",
             sb.max_tally, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
